@@ src/dtl_pkg.sv @@
// Package for the synthesizer tuning-word serial loader.
// Holds field widths, register indexes, strobe codes and the microprogram ROM.
// No dependencies; used by the interfaces and the top level.
package dtl_pkg;

  // Field widths.
  localparam int unsigned FreqW  = 32;
  localparam int unsigned CtrlW  = 8;
  localparam int unsigned KindW  = 2;
  localparam int unsigned WordW  = FreqW + CtrlW;
  localparam int unsigned CntW   = 6;
  localparam int unsigned PcW    = 3;
  localparam int unsigned CfgIdxW = 1;

  // Reset values of the configuration registers.
  localparam logic [FreqW-1:0] RefClkReset = 32'd180000000;
  localparam logic [CtrlW-1:0] CtrlReset   = 8'h01;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegRefClk = 1'b0;
  localparam logic [CfgIdxW-1:0] RegCtrl   = 1'b1;

  // Input action codes.
  localparam logic ActInit = 1'b0;
  localparam logic ActSet  = 1'b1;

  // Strobe kinds reported with each result.
  localparam logic [KindW-1:0] KindWclk  = 2'd0;
  localparam logic [KindW-1:0] KindFqud  = 2'd1;
  localparam logic [KindW-1:0] KindReset = 2'd2;

  // Loop bounds: one quotient bit per divide step, one serial bit per shift step.
  localparam logic [CntW-1:0] DivLast = 6'd63;
  localparam logic [CntW-1:0] SerLast = 6'(WordW - 1);

  // Microprogram addresses.
  localparam logic [PcW-1:0] PcIdle   = 3'd0;
  localparam logic [PcW-1:0] PcRst    = 3'd1;
  localparam logic [PcW-1:0] PcWclk   = 3'd2;
  localparam logic [PcW-1:0] PcFqudI  = 3'd3;
  localparam logic [PcW-1:0] PcDiv    = 3'd4;
  localparam logic [PcW-1:0] PcLoad   = 3'd5;
  localparam logic [PcW-1:0] PcShift  = 3'd6;
  localparam logic [PcW-1:0] PcFqudS  = 3'd7;

  // Sequencing of the step counter.
  typedef enum logic [1:0] {
    JmpNext   = 2'd0,
    JmpLoop   = 2'd1,
    JmpBranch = 2'd2,
    JmpIdle   = 2'd3
  } jmp_e;

  // Source of the data pin level in an emitted result.
  typedef enum logic [1:0] {
    DatZero = 2'd0,
    DatWord = 2'd1,
    DatHeld = 2'd2
  } dat_e;

  // One control word of the microprogram.
  typedef struct packed {
    logic             accept;
    logic             emit;
    logic [KindW-1:0] kind;
    logic             last;
    dat_e             dat;
    logic             freq_new;
    logic             div_step;
    logic             load_word;
    logic             shift;
    logic             commit;
    jmp_e             jmp;
    logic [CntW-1:0]  cnt_last;
  } cw_t;

  // Microprogram ROM.
  function automatic cw_t rom_word(input logic [PcW-1:0] pc);
    cw_t cw;
    cw = '{accept: 1'b0, emit: 1'b0, kind: KindWclk, last: 1'b0, dat: DatZero,
           freq_new: 1'b0, div_step: 1'b0, load_word: 1'b0, shift: 1'b0,
           commit: 1'b0, jmp: JmpIdle, cnt_last: '0};
    case (pc)
      PcIdle: begin
        cw.accept = 1'b1;
        cw.jmp    = JmpBranch;
      end
      PcRst: begin
        cw.emit = 1'b1;
        cw.kind = KindReset;
        cw.jmp  = JmpNext;
      end
      PcWclk: begin
        cw.emit = 1'b1;
        cw.kind = KindWclk;
        cw.jmp  = JmpNext;
      end
      PcFqudI: begin
        cw.emit = 1'b1;
        cw.kind = KindFqud;
        cw.last = 1'b1;
        cw.jmp  = JmpIdle;
      end
      PcDiv: begin
        cw.div_step = 1'b1;
        cw.jmp      = JmpLoop;
        cw.cnt_last = DivLast;
      end
      PcLoad: begin
        cw.load_word = 1'b1;
        cw.jmp       = JmpNext;
      end
      PcShift: begin
        cw.emit     = 1'b1;
        cw.kind     = KindWclk;
        cw.dat      = DatWord;
        cw.shift    = 1'b1;
        cw.jmp      = JmpLoop;
        cw.cnt_last = SerLast;
      end
      PcFqudS: begin
        cw.emit     = 1'b1;
        cw.kind     = KindFqud;
        cw.last     = 1'b1;
        cw.dat      = DatHeld;
        cw.freq_new = 1'b1;
        cw.commit   = 1'b1;
        cw.jmp      = JmpIdle;
      end
      default: begin
        cw.jmp = JmpIdle;
      end
    endcase
    return cw;
  endfunction

endpackage

@@ src/dtl_in_if.sv @@
// Input channel of the tuning-word loader: valid/ready plus the request payload.
// Depends on dtl_pkg for field widths.
interface dtl_in_if;
  logic                        valid;
  logic                        ready;
  logic                        action;
  logic [dtl_pkg::FreqW-1:0]   frequency_hz;

  modport source (output valid, output action, output frequency_hz, input ready);
  modport sink   (input valid, input action, input frequency_hz, output ready);
endinterface

@@ src/dtl_out_if.sv @@
// Output channel of the tuning-word loader: valid/ready plus one strobe result.
// Depends on dtl_pkg for field widths.
interface dtl_out_if;
  logic                        valid;
  logic                        ready;
  logic                        data_bit;
  logic [dtl_pkg::KindW-1:0]   strobe_kind;
  logic                        last;
  logic [dtl_pkg::FreqW-1:0]   frequency_in_use;

  modport source (output valid, output data_bit, output strobe_kind, output last,
                  output frequency_in_use, input ready);
  modport sink   (input valid, input data_bit, input strobe_kind, input last,
                  input frequency_in_use, output ready);
endinterface

@@ src/dds_tuning_word_serial_loader.sv @@
// Serial loader for a synthesizer frequency register, run by a microprogram.
// Init item: 3 results.
// Set item: 64 restoring-divide steps, 1 load step, 40 serial bits and 1 update strobe;
// items are accepted only in the idle step, so a new item waits until the last is done.
// Reset (async, active low) returns to idle with reference clock 180000000,
// control byte 0x01 and frequency in use 0. Depends on dtl_pkg and both interfaces.
module dds_tuning_word_serial_loader (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  dtl_in_if.sink                        in_i,
  dtl_out_if.source                     out_o,
  input  logic                          cfg_we_i,
  input  logic [dtl_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [dtl_pkg::FreqW-1:0]     cfg_wdata_i
);

  // Control state.
  logic [dtl_pkg::PcW-1:0]    pc_q, pc_d;
  logic [dtl_pkg::CntW-1:0]   cnt_q, cnt_d;
  logic                       out_valid_q, out_valid_d;

  // Configuration and programmed frequency.
  logic [dtl_pkg::FreqW-1:0]  ref_q;
  logic [dtl_pkg::CtrlW-1:0]  ctrl_q;
  logic [dtl_pkg::FreqW-1:0]  prog_q;

  // Datapath registers.
  logic [dtl_pkg::FreqW-1:0]  req_q;
  logic [dtl_pkg::FreqW-1:0]  dvd_q;
  logic [dtl_pkg::FreqW-1:0]  rem_q;
  logic [dtl_pkg::FreqW-1:0]  quot_q;
  logic [dtl_pkg::WordW-1:0]  word_q;
  logic                       held_q;

  // Output payload registers.
  logic                       o_bit_q;
  logic [dtl_pkg::KindW-1:0]  o_kind_q;
  logic                       o_last_q;
  logic [dtl_pkg::FreqW-1:0]  o_freq_q;

  dtl_pkg::cw_t               cw;
  logic                       in_xfer;
  logic                       out_busy;
  logic                       adv;
  logic                       loop_done;
  logic                       emit_now;
  logic                       emit_bit;
  logic [dtl_pkg::FreqW:0]    rem_sh;
  logic [dtl_pkg::FreqW+1:0]  diff;
  logic                       q_bit;

  // Decode the current step.
  assign cw        = dtl_pkg::rom_word(pc_q);
  assign in_i.ready = cw.accept;
  assign in_xfer   = in_i.valid & cw.accept;
  assign out_busy  = out_valid_q & ~out_o.ready;
  assign adv       = cw.accept ? in_i.valid : ~(cw.emit & out_busy);
  assign emit_now  = cw.emit & adv;
  assign loop_done = (cnt_q == cw.cnt_last);

  // Step counter and loop counter.
  always_comb begin
    pc_d  = pc_q;
    cnt_d = cnt_q;
    if (adv) begin
      case (cw.jmp)
        dtl_pkg::JmpNext: begin
          pc_d = pc_q + 3'd1;
        end
        dtl_pkg::JmpLoop: begin
          if (loop_done) begin
            pc_d  = pc_q + 3'd1;
            cnt_d = '0;
          end else begin
            cnt_d = cnt_q + 6'd1;
          end
        end
        dtl_pkg::JmpBranch: begin
          pc_d  = (in_i.action == dtl_pkg::ActSet) ? dtl_pkg::PcDiv : dtl_pkg::PcRst;
          cnt_d = '0;
        end
        dtl_pkg::JmpIdle: begin
          pc_d = dtl_pkg::PcIdle;
        end
        default: begin
          pc_d = dtl_pkg::PcIdle;
        end
      endcase
    end
  end

  // One restoring-division step: shift in the next dividend bit, trial subtract.
  assign rem_sh = {rem_q, dvd_q[dtl_pkg::FreqW-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, ref_q};
  assign q_bit  = ~diff[dtl_pkg::FreqW+1];

  // Data pin level for the result being emitted.
  always_comb begin
    case (cw.dat)
      dtl_pkg::DatZero: emit_bit = 1'b0;
      dtl_pkg::DatWord: emit_bit = word_q[0];
      dtl_pkg::DatHeld: emit_bit = held_q;
      default:          emit_bit = 1'b0;
    endcase
  end

  // Output valid: set on an emit, cleared once the result is transferred.
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit_now) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // Control and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= dtl_pkg::PcIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      ref_q       <= dtl_pkg::RefClkReset;
      ctrl_q      <= dtl_pkg::CtrlReset;
      prog_q      <= '0;
    end else begin
      pc_q        <= pc_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i && cfg_idx_i == dtl_pkg::RegRefClk) begin
        ref_q <= cfg_wdata_i;
      end
      if (cfg_we_i && cfg_idx_i == dtl_pkg::RegCtrl) begin
        ctrl_q <= cfg_wdata_i[dtl_pkg::CtrlW-1:0];
      end
      if (cw.commit && adv) begin
        prog_q <= req_q;
      end
    end
  end

  // Datapath and output payload registers.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      req_q <= in_i.frequency_hz;
      dvd_q <= in_i.frequency_hz;
      rem_q <= '0;
    end else if (cw.div_step) begin
      dvd_q  <= {dvd_q[dtl_pkg::FreqW-2:0], 1'b0};
      rem_q  <= q_bit ? diff[dtl_pkg::FreqW-1:0] : rem_sh[dtl_pkg::FreqW-1:0];
      quot_q <= {quot_q[dtl_pkg::FreqW-2:0], q_bit};
    end
    if (cw.load_word) begin
      word_q <= {ctrl_q, quot_q};
    end else if (cw.shift && adv) begin
      word_q <= {1'b0, word_q[dtl_pkg::WordW-1:1]};
      held_q <= word_q[0];
    end
    if (emit_now) begin
      o_bit_q  <= emit_bit;
      o_kind_q <= cw.kind;
      o_last_q <= cw.last;
      o_freq_q <= cw.freq_new ? req_q : prog_q;
    end
  end

  // Result channel.
  assign out_o.valid            = out_valid_q;
  assign out_o.data_bit         = o_bit_q;
  assign out_o.strobe_kind      = o_kind_q;
  assign out_o.last             = o_last_q;
  assign out_o.frequency_in_use = o_freq_q;

`ifndef SYNTH
  // The divide loop exits only after all 64 quotient bits.
  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(pc_q) == dtl_pkg::PcDiv && pc_q == dtl_pkg::PcLoad) |->
      $past(cnt_q) == dtl_pkg::DivLast)
    else $error("divide loop left early");

  // The serial loop never counts past the last word bit.
  a_ser_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == dtl_pkg::PcShift) |-> (cnt_q <= dtl_pkg::SerLast))
    else $error("serial bit counter overran");

  // The frequency in use changes only together with the final update strobe.
  a_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(prog_q) |-> (out_valid_q && o_last_q && o_kind_q == dtl_pkg::KindFqud))
    else $error("frequency committed without update strobe");

  // An item is accepted only when no loop count is pending.
  a_idle_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |-> (cnt_q == '0))
    else $error("item accepted with loop counter busy");
`endif

endmodule

@@ verif/tb_dds_tuning_word_serial_loader.sv @@
// Self-checking testbench for the tuning-word serial loader.
// A directed table and randomized register phases run against an in-bench strobe predictor.
// Depends on dtl_pkg, dtl_in_if, dtl_out_if and dds_tuning_word_serial_loader.
`timescale 1ns / 1ps

module tb_dds_tuning_word_serial_loader;

  localparam int unsigned LongHold   = 300;
  localparam int unsigned RandPhases = 8;
  localparam int unsigned PhaseItems = 56;
  localparam int unsigned TailCycles = 20;

  typedef enum logic {
    RowItem,
    RowRegs
  } row_e;

  typedef enum int {
    ReadyAlways,
    ReadyCoin,
    ReadyRuns
  } ready_mode_e;

  // One directed step: a request, or a write of both registers.
  typedef struct packed {
    row_e                       kind;
    logic                       action;
    logic [dtl_pkg::FreqW-1:0]  hz;
    logic                       typed;
    logic [dtl_pkg::FreqW-1:0]  word;
    logic [dtl_pkg::FreqW-1:0]  ref_clk;
    logic [dtl_pkg::CtrlW-1:0]  ctrl;
  } step_t;

  // One strobe as seen on the output channel.
  typedef struct packed {
    logic                       data_bit;
    logic [dtl_pkg::KindW-1:0]  kind;
    logic                       last;
    logic [dtl_pkg::FreqW-1:0]  in_use;
  } strobe_t;

  // Columns: kind, action, frequency, typed, tuning word, reference clock, control byte.
  // Typed rows carry a tuning word that follows directly from the division.
  localparam step_t DirectedSteps [27] = '{
    '{RowItem, dtl_pkg::ActInit, 32'd0,         1'b1, 32'd0,         32'd0,         8'h00},
    '{RowItem, dtl_pkg::ActSet,  32'd0,         1'b1, 32'd0,         32'd0,         8'h00},
    '{RowItem, dtl_pkg::ActSet,  32'd90000000,  1'b1, 32'h80000000,  32'd0,         8'h00},
    '{RowItem, dtl_pkg::ActSet,  32'd180000000, 1'b1, 32'd0,         32'd0,         8'h00},
    '{RowItem, dtl_pkg::ActSet,  32'd1,         1'b1, 32'd23,        32'd0,         8'h00},
    '{RowItem, dtl_pkg::ActInit, 32'd0,         1'b0, 32'd0,         32'd0,         8'h00},
    '{RowItem, dtl_pkg::ActSet,  32'hFFFFFFFF,  1'b0, 32'd0,         32'd0,         8'h00},
    '{RowRegs, dtl_pkg::ActSet,  32'd0,         1'b0, 32'd0,         32'd0,         8'hFF},
    '{RowItem, dtl_pkg::ActSet,  32'd12345,     1'b1, 32'hFFFFFFFF,  32'd0,         8'h00},
    '{RowItem, dtl_pkg::ActSet,  32'd0,         1'b1, 32'hFFFFFFFF,  32'd0,         8'h00},
    '{RowItem, dtl_pkg::ActInit, 32'hFFFFFFFF,  1'b0, 32'd0,         32'd0,         8'h00},
    '{RowRegs, dtl_pkg::ActSet,  32'd0,         1'b0, 32'd0,         32'd1,         8'h00},
    '{RowItem, dtl_pkg::ActSet,  32'hFFFFFFFF,  1'b1, 32'd0,         32'd0,         8'h00},
    '{RowItem, dtl_pkg::ActSet,  32'd1,         1'b1, 32'd0,         32'd0,         8'h00},
    '{RowRegs, dtl_pkg::ActSet,  32'd0,         1'b0, 32'd0,         32'hFFFFFFFF,  8'h80},
    '{RowItem, dtl_pkg::ActSet,  32'hFFFFFFFF,  1'b1, 32'd0,         32'd0,         8'h00},
    '{RowItem, dtl_pkg::ActSet,  32'hFFFFFFFE,  1'b1, 32'hFFFFFFFE,  32'd0,         8'h00},
    '{RowItem, dtl_pkg::ActSet,  32'd1,         1'b1, 32'd1,         32'd0,         8'h00},
    '{RowItem, dtl_pkg::ActSet,  32'h80000000,  1'b1, 32'h80000000,  32'd0,         8'h00},
    '{RowRegs, dtl_pkg::ActSet,  32'd0,         1'b0, 32'd0,         32'd125000000, 8'h7F},
    '{RowItem, dtl_pkg::ActSet,  32'd1000000,   1'b0, 32'd0,         32'd0,         8'h00},
    '{RowItem, dtl_pkg::ActSet,  32'h55555555,  1'b0, 32'd0,         32'd0,         8'h00},
    '{RowItem, dtl_pkg::ActSet,  32'hAAAAAAAA,  1'b0, 32'd0,         32'd0,         8'h00},
    '{RowItem, dtl_pkg::ActInit, 32'h12345678,  1'b0, 32'd0,         32'd0,         8'h00},
    '{RowRegs, dtl_pkg::ActSet,  32'd0,         1'b0, 32'd0,         32'd180000000, 8'h01},
    '{RowItem, dtl_pkg::ActSet,  32'd10000000,  1'b0, 32'd0,         32'd0,         8'h00},
    '{RowItem, dtl_pkg::ActSet,  32'hDEADBEEF,  1'b0, 32'd0,         32'd0,         8'h00}
  };

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [dtl_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [dtl_pkg::FreqW-1:0]    cfg_wdata_i;

  dtl_in_if  req_ch ();
  dtl_out_if strobe_ch ();

  dds_tuning_word_serial_loader dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (req_ch),
    .out_o       (strobe_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Predictor state, kept in step with the register writes and accepted requests.
  logic [dtl_pkg::FreqW-1:0] ref_clk_hz;
  logic [dtl_pkg::CtrlW-1:0] ctrl_byte;
  logic [dtl_pkg::FreqW-1:0] freq_programmed;
  strobe_t                   pending_strobes [$];
  strobe_t                   head;

  int mismatches      = 0;
  int strobes_checked = 0;
  int n_set           = 0;
  int n_init          = 0;
  int n_settings      = 0;
  int hold_requests   = 0;
  int holds_served    = 0;

  // Clock: 4 ns period.
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Reset is asserted at the start of the run only.
  initial begin
    rst_ni <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Hard stop in case the block hangs.
  initial begin
    #4_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Tuning word: low 32 bits of hz * 2^32 / reference clock, all ones for a zero divisor.
  function automatic logic [dtl_pkg::FreqW-1:0] tuning_word(
      input logic [dtl_pkg::FreqW-1:0] hz);
    logic [2*dtl_pkg::FreqW-1:0] quot;
    if (ref_clk_hz == '0) begin
      return '1;
    end
    quot = {hz, {dtl_pkg::FreqW{1'b0}}} / {{dtl_pkg::FreqW{1'b0}}, ref_clk_hz};
    return quot[dtl_pkg::FreqW-1:0];
  endfunction

  // Queue the strobes that one accepted request produces.
  function automatic void predict_strobes(input logic action,
                                          input logic [dtl_pkg::FreqW-1:0] hz,
                                          input logic [dtl_pkg::FreqW-1:0] word);
    logic [dtl_pkg::WordW-1:0] shift_word;
    if (action == dtl_pkg::ActInit) begin
      pending_strobes.push_back(strobe_t'{1'b0, dtl_pkg::KindReset, 1'b0, freq_programmed});
      pending_strobes.push_back(strobe_t'{1'b0, dtl_pkg::KindWclk, 1'b0, freq_programmed});
      pending_strobes.push_back(strobe_t'{1'b0, dtl_pkg::KindFqud, 1'b1, freq_programmed});
      n_init++;
    end else begin
      // Tuning word bytes go out low bit first, then the control byte.
      shift_word = {ctrl_byte, word};
      for (int i = 0; i < dtl_pkg::WordW; i++) begin
        pending_strobes.push_back(strobe_t'{shift_word[i], dtl_pkg::KindWclk, 1'b0,
                                            freq_programmed});
      end
      // The new frequency takes effect at the update strobe; the data pin holds bit 39.
      freq_programmed = hz;
      pending_strobes.push_back(strobe_t'{ctrl_byte[dtl_pkg::CtrlW-1], dtl_pkg::KindFqud, 1'b1,
                                          freq_programmed});
      n_set++;
    end
  endfunction

  // Offer one request and hold it until the transfer happens.
  task automatic send_request(input logic action, input logic [dtl_pkg::FreqW-1:0] hz,
                              input logic typed, input logic [dtl_pkg::FreqW-1:0] word);
    req_ch.valid        <= 1'b1;
    req_ch.action       <= action;
    req_ch.frequency_hz <= hz;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    predict_strobes(action, hz, typed ? word : tuning_word(hz));
  endtask

  // Stop offering and wait until every queued strobe has come out.
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (pending_strobes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write both registers; the upper bits of the control write must be ignored.
  task automatic write_regs(input logic [dtl_pkg::FreqW-1:0] ref_clk,
                            input logic [dtl_pkg::CtrlW-1:0] ctrl);
    logic [dtl_pkg::FreqW-1:0] junk;
    junk = $urandom;
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= dtl_pkg::RegRefClk;
    cfg_wdata_i <= ref_clk;
    @(posedge clk_i);
    cfg_idx_i   <= dtl_pkg::RegCtrl;
    cfg_wdata_i <= {junk[dtl_pkg::FreqW-1:dtl_pkg::CtrlW], ctrl};
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    ref_clk_hz  = ref_clk;
    ctrl_byte   = ctrl;
    n_settings++;
  endtask

  // Output stall pattern: segments of always-ready, coin-flip and stall runs,
  // with long holds on request from the stimulus.
  initial begin
    int          hold_left;
    int          run_left;
    int          seg_left;
    ready_mode_e mode;
    hold_left = 0;
    run_left  = 0;
    seg_left  = 0;
    mode      = ReadyAlways;
    strobe_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_left == 0 && holds_served < hold_requests) begin
        hold_left = LongHold;
        holds_served++;
      end
      if (seg_left == 0) begin
        mode     = ready_mode_e'($urandom_range(0, 2));
        seg_left = $urandom_range(20, 200);
      end
      seg_left--;
      if (hold_left != 0) begin
        hold_left--;
        strobe_ch.ready <= 1'b0;
      end else begin
        case (mode)
          ReadyAlways: begin
            strobe_ch.ready <= 1'b1;
          end
          ReadyCoin: begin
            strobe_ch.ready <= 1'($urandom_range(0, 1));
          end
          default: begin
            if (run_left != 0) begin
              run_left--;
              strobe_ch.ready <= 1'b0;
            end else begin
              strobe_ch.ready <= 1'b1;
              run_left = $urandom_range(0, 7);
            end
          end
        endcase
      end
    end
  end

  // Compare every output transfer with the oldest predicted strobe.
  always @(posedge clk_i) begin
    if (rst_ni && strobe_ch.valid && strobe_ch.ready) begin
      if (pending_strobes.size() == 0) begin
        $error("strobe with nothing pending: strobe_kind %0d", strobe_ch.strobe_kind);
        mismatches++;
      end else begin
        head = pending_strobes.pop_front();
        strobes_checked++;
        if (strobe_ch.data_bit !== head.data_bit) begin
          $error("data_bit: expected %0d, got %0d", head.data_bit, strobe_ch.data_bit);
          mismatches++;
        end
        if (strobe_ch.strobe_kind !== head.kind) begin
          $error("strobe_kind: expected %0d, got %0d", head.kind, strobe_ch.strobe_kind);
          mismatches++;
        end
        if (strobe_ch.last !== head.last) begin
          $error("last: expected %0d, got %0d", head.last, strobe_ch.last);
          mismatches++;
        end
        if (strobe_ch.frequency_in_use !== head.in_use) begin
          $error("frequency_in_use: expected %0d, got %0d", head.in_use,
                 strobe_ch.frequency_in_use);
          mismatches++;
        end
      end
    end
  end

  // Stimulus: directed table first, then randomized register phases.
  initial begin
    int                        burst_left;
    int                        gap;
    logic                      act;
    logic [dtl_pkg::FreqW-1:0] hz;
    logic [dtl_pkg::FreqW-1:0] ref_clk;
    logic [dtl_pkg::CtrlW-1:0] ctrl;
    req_ch.valid        <= 1'b0;
    req_ch.action       <= dtl_pkg::ActInit;
    req_ch.frequency_hz <= '0;
    cfg_we_i            <= 1'b0;
    cfg_idx_i           <= dtl_pkg::RegRefClk;
    cfg_wdata_i         <= '0;
    ref_clk_hz          = dtl_pkg::RefClkReset;
    ctrl_byte           = dtl_pkg::CtrlReset;
    freq_programmed     = '0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);

    foreach (DirectedSteps[i]) begin
      if (DirectedSteps[i].kind == RowRegs) begin
        drain();
        write_regs(DirectedSteps[i].ref_clk, DirectedSteps[i].ctrl);
      end else begin
        send_request(DirectedSteps[i].action, DirectedSteps[i].hz, DirectedSteps[i].typed,
                     DirectedSteps[i].word);
      end
    end

    for (int phase = 0; phase < RandPhases; phase++) begin
      drain();
      // Pick a register setting, leaning on the extremes now and then.
      case ($urandom_range(0, 9))
        0:       ref_clk = '0;
        1:       ref_clk = 32'd1;
        2:       ref_clk = '1;
        3:       ref_clk = 32'd180000000;
        4:       ref_clk = 32'd125000000;
        5:       ref_clk = $urandom_range(2, 1000);
        default: ref_clk = $urandom;
      endcase
      case ($urandom_range(0, 3))
        0:       ctrl = 8'h00;
        1:       ctrl = 8'hFF;
        default: ctrl = 8'($urandom);
      endcase
      write_regs(ref_clk, ctrl);
      // In two phases the output side holds off long enough to back up the input.
      if (phase == 2 || phase == 5) begin
        hold_requests++;
      end
      burst_left = 0;
      repeat (PhaseItems) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 8);
          gap = (phase % 3 == 0) ? 0 : $urandom_range(0, 12);
          if (gap != 0) begin
            req_ch.valid        <= 1'b0;
            req_ch.action       <= 1'($urandom);
            req_ch.frequency_hz <= $urandom;
            repeat (gap) @(posedge clk_i);
          end
        end
        burst_left--;
        act = ($urandom_range(0, 4) == 0) ? dtl_pkg::ActInit : dtl_pkg::ActSet;
        case ($urandom_range(0, 7))
          0:       hz = '0;
          1:       hz = '1;
          2:       hz = $urandom_range(0, 1000);
          3:       hz = ref_clk_hz + $urandom_range(0, 2) - 1;
          default: hz = $urandom;
        endcase
        send_request(act, hz, 1'b0, '0);
      end
    end

    drain();
    repeat (TailCycles) @(posedge clk_i);

    $display("Checked %0d strobes from %0d set-frequency and %0d init requests,",
             strobes_checked, n_set, n_init);
    $display("over %0d register settings with %0d long output holds.",
             n_settings, hold_requests);
    if (mismatches == 0 && pending_strobes.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/dtl_pkg.sv
src/dtl_in_if.sv
src/dtl_out_if.sv
src/dds_tuning_word_serial_loader.sv
verif/tb_dds_tuning_word_serial_loader.sv
